// ===== hw/rtl/bfd_pkg.sv =====
// ----------------------------------------------------------------------------
// Biopotential frame decoder package
// Shared types, register indexes and gain tables of the frame decoder.
// ----------------------------------------------------------------------------
package bfd_pkg;

  localparam int unsigned FRAME_BYTES = 9;
  localparam int unsigned STORE_DEPTH = 8;
  localparam int unsigned SAMPLE_W    = 24;
  localparam int unsigned SCALE_W     = 20;
  localparam int unsigned PROD_W      = SAMPLE_W + SCALE_W;
  localparam int unsigned DIVISOR_W   = 17;
  localparam int unsigned GAIN_W      = 4;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 20;
  localparam int unsigned RESULT_W    = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_FIRST     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_SECOND    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VOLTS_PER_STEP = 2'd2;

  localparam logic [GAIN_W-1:0] GAIN_RESET = 4'd6;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_start;
  } in_item_t;

  typedef struct packed {
    logic                       bias_lead_off;
    logic                       second_neg_lead_off;
    logic                       second_pos_lead_off;
    logic                       first_neg_lead_off;
    logic                       first_pos_lead_off;
    logic signed [RESULT_W-1:0] first_microvolts;
    logic signed [RESULT_W-1:0] second_microvolts;
  } out_item_t;

  function automatic logic gain_ok(input logic [CFG_DATA_W-1:0] g);
    return g == 20'd1 || g == 20'd2 || g == 20'd3 || g == 20'd4 ||
           g == 20'd6 || g == 20'd8 || g == 20'd12;
  endfunction

  function automatic logic [DIVISOR_W-1:0] gain_divisor(input logic [GAIN_W-1:0] g);
    logic [DIVISOR_W-1:0] d;
    case (g)
      4'd2:    d = 17'd20000;
      4'd3:    d = 17'd30000;
      4'd4:    d = 17'd40000;
      4'd6:    d = 17'd60000;
      4'd8:    d = 17'd80000;
      4'd12:   d = 17'd120000;
      default: d = 17'd10000;
    endcase
    return d;
  endfunction

endpackage

// ===== hw/rtl/bfd_stream_if.sv =====
// ----------------------------------------------------------------------------
// Frame decoder stream interface
// Valid/ready channel carrying one request payload of a packed type.
// ----------------------------------------------------------------------------
interface bfd_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/bfd_cfg_if.sv =====
// ----------------------------------------------------------------------------
// Frame decoder configuration interface
// Valid/ready register write channel with index and data.
// ----------------------------------------------------------------------------
interface bfd_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [bfd_pkg::CFG_IDX_W-1:0]     index;
  logic [bfd_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/biopotential_frame_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// Biopotential frame decoder unit
// Collects a nine-byte converter frame and delivers lead-off flags and both
// channel samples scaled to microvolts.
// ----------------------------------------------------------------------------
//   Channel  Direction  Payload
//   in_i     sink       frame_byte, frame_start
//   cfg_i    sink       index, data
//   out_o    source     five lead-off flags, two 32-bit microvolt samples
//
// The first eight bytes are stored as they arrive. The ninth byte starts a
// shared shift-add multiplier and restoring divider that run once per
// channel; input requests stall from then until the result is moved into
// the output register. The result is held in an output register and the
// next frame is collected while it waits. Reset clears the position, the
// controller, the output valid and vps_q, and loads the gain defaults.
module biopotential_frame_decoder_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  bfd_stream_if.sink    in_i,
  bfd_cfg_if.sink       cfg_i,
  bfd_stream_if.source  out_o
);
  import bfd_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  localparam int unsigned CNT_W = $clog2(PROD_W);
  localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(SCALE_W - 1);
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(PROD_W - 1);
  localparam logic [3:0] LAST_POS = 4'(FRAME_BYTES - 1);

  logic [1:0]              state_q, state_d;
  logic [3:0]              pos_q, pos_d, pos_eff;
  logic [7:0]              store_q [STORE_DEPTH];
  logic [GAIN_W-1:0]       gain_first_q, gain_second_q;
  logic [SCALE_W-1:0]      vps_q;
  logic [SAMPLE_W-1:0]     samp2_q;
  logic [SAMPLE_W-1:0]     mag_q, mag_d;
  logic                    neg_q, neg_d;
  logic                    ch_q, ch_d;
  logic [CNT_W-1:0]        cnt_q, cnt_d;
  logic [PROD_W-1:0]       p_q, p_d;
  logic [DIVISOR_W-1:0]    rem_q, rem_d;
  logic [RESULT_W-1:0]     res1_q, res1_d;
  logic [RESULT_W-1:0]     res2_q, res2_d;
  logic                    out_valid_q, out_valid_d;
  out_item_t               out_q, out_d;

  logic                    in_fire, out_fire, frame_end, out_load;
  logic [SAMPLE_W-1:0]     load_samp;
  logic [SAMPLE_W-1:0]     load_mag;
  logic [SAMPLE_W:0]       mul_sum;
  logic [DIVISOR_W-1:0]    divisor;
  logic [DIVISOR_W:0]      rem_sh;
  logic                    rem_ge;
  logic [RESULT_W-1:0]     quot, signed_res;

  assign in_i.ready  = (state_q == ST_IDLE);
  assign cfg_i.ready = 1'b1;
  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;

  assign in_fire  = in_i.valid && in_i.ready;
  assign out_fire = out_valid_q && out_o.ready;

  always_comb begin
    pos_eff = in_i.payload.frame_start ? 4'd0 : pos_q;
    if (pos_eff > LAST_POS) begin
      pos_eff = 4'd0;
    end
  end

  assign frame_end = in_fire && (pos_eff == LAST_POS);
  assign out_load  = (state_q == ST_DONE) && (!out_valid_q || out_o.ready);

  assign load_samp = frame_end ? {store_q[3], store_q[4], store_q[5]} : samp2_q;
  assign load_mag  = load_samp[SAMPLE_W-1] ? SAMPLE_W'(-load_samp) : load_samp;

  assign mul_sum = {1'b0, p_q[PROD_W-1:SCALE_W]} + (p_q[0] ? {1'b0, mag_q} : '0);
  assign divisor = gain_divisor(ch_q ? gain_second_q : gain_first_q);
  assign rem_sh  = {rem_q, p_q[PROD_W-1]};
  assign rem_ge  = rem_sh >= {1'b0, divisor};
  assign quot    = {p_q[RESULT_W-2:0], rem_ge};
  assign signed_res = neg_q ? RESULT_W'(-quot) : quot;

  always_comb begin
    state_d     = state_q;
    pos_d       = pos_q;
    mag_d       = mag_q;
    neg_d       = neg_q;
    ch_d        = ch_q;
    cnt_d       = cnt_q;
    p_d         = p_q;
    rem_d       = rem_q;
    res1_d      = res1_q;
    res2_d      = res2_q;
    out_valid_d = out_fire ? 1'b0 : out_valid_q;
    out_d       = out_q;

    if (in_fire) begin
      pos_d = frame_end ? 4'd0 : pos_eff + 4'd1;
    end

    case (state_q)
      ST_IDLE: begin
        if (frame_end) begin
          state_d = ST_MUL;
          ch_d    = 1'b0;
          cnt_d   = '0;
          mag_d   = load_mag;
          neg_d   = load_samp[SAMPLE_W-1];
          p_d     = {{SAMPLE_W{1'b0}}, vps_q};
        end
      end
      ST_MUL: begin
        p_d   = {mul_sum, p_q[SCALE_W-1:1]};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == MUL_LAST) begin
          state_d = ST_DIV;
          cnt_d   = '0;
          rem_d   = '0;
        end
      end
      ST_DIV: begin
        rem_d = rem_ge ? DIVISOR_W'(rem_sh - {1'b0, divisor}) : rem_sh[DIVISOR_W-1:0];
        p_d   = {p_q[PROD_W-2:0], rem_ge};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == DIV_LAST) begin
          cnt_d = '0;
          if (!ch_q) begin
            res1_d  = signed_res;
            ch_d    = 1'b1;
            state_d = ST_MUL;
            mag_d   = load_mag;
            neg_d   = load_samp[SAMPLE_W-1];
            p_d     = {{SAMPLE_W{1'b0}}, vps_q};
          end else begin
            res1_d  = res1_q;
            res2_d  = signed_res;
            state_d = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        if (out_load) begin
          out_d.bias_lead_off       = store_q[0][3];
          out_d.second_neg_lead_off = store_q[0][2];
          out_d.second_pos_lead_off = store_q[0][1];
          out_d.first_neg_lead_off  = store_q[0][0];
          out_d.first_pos_lead_off  = store_q[1][7];
          out_d.first_microvolts    = res1_q;
          out_d.second_microvolts   = res2_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      pos_q         <= '0;
      out_valid_q   <= 1'b0;
      gain_first_q  <= GAIN_RESET;
      gain_second_q <= GAIN_RESET;
      vps_q         <= '0;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
      if (cfg_i.valid) begin
        case (cfg_i.index)
          CFG_GAIN_FIRST: begin
            if (gain_ok(cfg_i.data)) begin
              gain_first_q <= cfg_i.data[GAIN_W-1:0];
            end
          end
          CFG_GAIN_SECOND: begin
            if (gain_ok(cfg_i.data)) begin
              gain_second_q <= cfg_i.data[GAIN_W-1:0];
            end
          end
          CFG_VOLTS_PER_STEP: begin
            vps_q <= cfg_i.data[SCALE_W-1:0];
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && !frame_end) begin
      store_q[pos_eff[2:0]] <= in_i.payload.frame_byte;
    end
    if (frame_end) begin
      samp2_q <= {store_q[6], store_q[7], in_i.payload.frame_byte};
    end
    mag_q  <= mag_d;
    neg_q  <= neg_d;
    ch_q   <= ch_d;
    cnt_q  <= cnt_d;
    p_q    <= p_d;
    rem_q  <= rem_d;
    res1_q <= res1_d;
    res2_q <= res2_d;
    out_q  <= out_d;
  end

  a_frame_starts_mul : assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_end |=> (state_q == ST_MUL) && !ch_q)
    else $error("ninth byte did not start the multiplier");

  a_gains_legal : assert property (@(posedge clk_i) disable iff (!rst_ni)
    gain_ok(CFG_DATA_W'(gain_first_q)) && gain_ok(CFG_DATA_W'(gain_second_q)))
    else $error("gain register holds an unsupported value");

  a_valid_from_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == ST_DONE))
    else $error("result presented outside the completion state");

  a_pos_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= LAST_POS)
    else $error("byte position out of range");

endmodule
